// File: hw/rtl/fmsv_pkg.sv
// ---------------------------------------------------------------------------
// FIX message syntax validator package
// Shared widths, constants and the header pattern of the syntax validator.
// ---------------------------------------------------------------------------
package fmsv_pkg;

   localparam int unsigned BYTE_W        = 8;
   localparam int unsigned COUNT_W       = 4;
   localparam int unsigned HDR_IDX_W     = 3;

   localparam logic [COUNT_W-1:0] MIN_MSG_BYTES = 4'd10;
   localparam logic [COUNT_W-1:0] HDR_BYTES     = 4'd6;

   localparam logic [BYTE_W-1:0] SEP_RESET      = 8'd124;
   localparam logic [BYTE_W-1:0] PRINT_LO       = 8'd32;
   localparam logic [BYTE_W-1:0] PRINT_HI       = 8'd126;
   localparam logic [BYTE_W-1:0] CHAR_EQUALS    = 8'h3D;
   localparam logic [BYTE_W-1:0] CHAR_ZERO      = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_THREE     = 8'h33;
   localparam logic [BYTE_W-1:0] CHAR_FIVE      = 8'h35;
   localparam logic [BYTE_W-1:0] CHAR_EIGHT     = 8'h38;
   localparam logic [BYTE_W-1:0] CHAR_NINE      = 8'h39;

   typedef enum logic [2:0] {
      TAG_OTHER       = 3'd0,
      TAG_EIGHT       = 3'd1,
      TAG_NINE        = 3'd2,
      TAG_THREE       = 3'd3,
      TAG_THIRTY_FIVE = 3'd4
   } tag_class_type;

   // "8=FIX." indexed by byte position
   function automatic logic [BYTE_W-1:0] header_byte(input logic [HDR_IDX_W-1:0] idx);
      logic [BYTE_W-1:0] chr;
      case (idx)
         3'd0:    chr = 8'h38;
         3'd1:    chr = 8'h3D;
         3'd2:    chr = 8'h46;
         3'd3:    chr = 8'h49;
         3'd4:    chr = 8'h58;
         3'd5:    chr = 8'h2E;
         default: chr = 8'h00;
      endcase
      return chr;
   endfunction

endpackage

// File: hw/rtl/fix_message_syntax_validator.sv
// ---------------------------------------------------------------------------
// FIX message syntax validator
// Checks tag=value syntax, header, minimum length and required tags 8/9/35,
// one byte per beat, verdict on the last byte of each message.
// ---------------------------------------------------------------------------
// The verdict appears on rsp in the cycle after the last byte's beat.
// Throughput: one byte per cycle while rsp is not stalled; per-byte state update is a single
//   combinational pass between the message state registers.
// Reset: synchronous, clears message state and output valid; the separator
//   register returns to '|'.
module fix_message_syntax_validator (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [fmsv_pkg::BYTE_W-1:0] csr_wdata,   // field_separator
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [fmsv_pkg::BYTE_W-1:0] req_tdata,   // [7:0] data_byte
   input  logic                        req_tlast,   // last_byte
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [7:0]                  rsp_tdata    // [0] message_ok, [7:1] zero
);
   import fmsv_pkg::*;

   logic [BYTE_W-1:0]  sep_ff;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic               in_value_ff, in_value_in;
   logic               vlz_ff, vlz_in;
   logic [1:0]         digits_ff, digits_in;
   tag_class_type      class_ff, class_in;
   logic               seen8_ff, seen8_in;
   logic               seen9_ff, seen9_in;
   logic               seen35_ff, seen35_in;
   logic               err_ff, err_in;
   logic               rsp_valid_ff;
   logic               rsp_ok_ff;

   logic               accept;
   logic               hdr_err;
   logic               is_digit;
   logic               printable;
   logic               msg_ok;
   logic [BYTE_W-1:0]  b;

   assign b          = req_tdata;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_ok_ff};

   assign hdr_err   = (cnt_ff < HDR_BYTES) && (b != header_byte(cnt_ff[HDR_IDX_W-1:0]));
   assign is_digit  = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
   assign printable = (b >= PRINT_LO) && (b <= PRINT_HI);

   always_comb begin
      cnt_in      = (cnt_ff < MIN_MSG_BYTES) ? cnt_ff + 4'd1 : cnt_ff;
      err_in      = err_ff || hdr_err;
      in_value_in = in_value_ff;
      vlz_in      = vlz_ff;
      digits_in   = digits_ff;
      class_in    = class_ff;
      seen8_in    = seen8_ff;
      seen9_in    = seen9_ff;
      seen35_in   = seen35_ff;

      if (!err_in) begin
         if (!in_value_ff) begin
            // separator wins over '=' and digits
            if (b == sep_ff) begin
               err_in = 1'b1;
            end else if (b == CHAR_EQUALS) begin
               in_value_in = 1'b1;
               vlz_in      = 1'b1;
            end else if (is_digit) begin
               class_in = TAG_OTHER;
               case (digits_ff)
                  2'd0: begin
                     if (b == CHAR_EIGHT)      class_in = TAG_EIGHT;
                     else if (b == CHAR_NINE)  class_in = TAG_NINE;
                     else if (b == CHAR_THREE) class_in = TAG_THREE;
                  end
                  2'd1: begin
                     if (class_ff == TAG_THREE && b == CHAR_FIVE) class_in = TAG_THIRTY_FIVE;
                  end
                  default: class_in = TAG_OTHER;
               endcase
               if (digits_ff != 2'd3) digits_in = digits_ff + 2'd1;
            end else begin
               err_in = 1'b1;
            end
         end else begin
            if (b == sep_ff) begin
               if (vlz_ff) begin
                  err_in = 1'b1;
               end else begin
                  if (class_ff == TAG_EIGHT)            seen8_in  = 1'b1;
                  else if (class_ff == TAG_NINE)        seen9_in  = 1'b1;
                  else if (class_ff == TAG_THIRTY_FIVE) seen35_in = 1'b1;
                  in_value_in = 1'b0;
                  vlz_in      = 1'b1;
                  digits_in   = 2'd0;
                  class_in    = TAG_OTHER;
               end
            end else if (!printable) begin
               err_in = 1'b1;
            end else begin
               vlz_in = 1'b0;
            end
         end
      end

      msg_ok = !err_in && (cnt_in >= MIN_MSG_BYTES) && (b == sep_ff) && !in_value_in
               && seen8_in && seen9_in && seen35_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sep_ff       <= SEP_RESET;
         cnt_ff       <= '0;
         in_value_ff  <= 1'b0;
         vlz_ff       <= 1'b1;
         digits_ff    <= 2'd0;
         class_ff     <= TAG_OTHER;
         seen8_ff     <= 1'b0;
         seen9_ff     <= 1'b0;
         seen35_ff    <= 1'b0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            sep_ff <= csr_wdata;
         end
         if (accept) begin
            if (req_tlast) begin
               // message over, back to a clean start
               cnt_ff      <= '0;
               in_value_ff <= 1'b0;
               vlz_ff      <= 1'b1;
               digits_ff   <= 2'd0;
               class_ff    <= TAG_OTHER;
               seen8_ff    <= 1'b0;
               seen9_ff    <= 1'b0;
               seen35_ff   <= 1'b0;
               err_ff      <= 1'b0;
            end else begin
               cnt_ff      <= cnt_in;
               in_value_ff <= in_value_in;
               vlz_ff      <= vlz_in;
               digits_ff   <= digits_in;
               class_ff    <= class_in;
               seen8_ff    <= seen8_in;
               seen9_ff    <= seen9_in;
               seen35_ff   <= seen35_in;
               err_ff      <= err_in;
            end
         end
         if (req_tready) begin
            rsp_valid_ff <= accept && req_tlast;
         end
      end
   end

   // verdict payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_tready) begin
         rsp_ok_ff <= msg_ok;
      end
   end

endmodule

// File: hw/rtl/fmsv_checker.sv
// ---------------------------------------------------------------------------
// FIX message syntax validator checker
// Port-level properties of the validator, bound to the top level.
// ---------------------------------------------------------------------------
module fmsv_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       req_tlast,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   // stalled verdict beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");

   // only one verdict bit, padding is zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:1] == 7'd0)
      else $error("rsp padding bits not zero");

   // last byte of a message yields a verdict next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> rsp_tvalid)
      else $error("no verdict after last byte");

   // a byte that is not last, with the output free, yields nothing
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tlast && !(rsp_tvalid && !rsp_tready)
      |=> !rsp_tvalid)
      else $error("verdict without last byte");

endmodule

bind fix_message_syntax_validator fmsv_checker u_fmsv_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
